@@ src/stl_lpca_pkg.sv @@
// Package for the STL low-pass cascade average.
// Holds shared constants and types; no dependencies.
`default_nettype none
package stl_lpca_pkg;
    localparam int unsigned PeriodBits = 9;
    localparam logic [PeriodBits-1:0] PeriodReset = 9'd12;
    localparam int unsigned CfgAddrBits = 1;
    localparam logic [CfgAddrBits-1:0] RegPeriod = 1'b0;
    localparam int unsigned OutBits = 24;

    typedef enum logic [2:0] {
        t_BK_IDLE,
        t_BK_RD,
        t_BK_DIV1,
        t_BK_DIV2,
        t_BK_DIV3,
        t_BK_OUT
    } t_bk_state;
endpackage
`default_nettype wire

@@ src/stl_lpca_if.sv @@
// Valid/ready channel interface carrying one payload word.
// No dependencies.
`default_nettype none
interface stl_lpca_if #(parameter int W = 25) ();
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/stl_lpca_div.sv @@
// Shared iterative signed divider, one quotient bit a cycle, truncation toward zero.
// Depends on nothing.
`default_nettype none
module stl_lpca_div #(
    parameter int NB = 34,
    parameter int DB = 9
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [NB-1:0] i_num,
    input  wire logic [DB-1:0] i_den,
    output logic               o_done,
    output logic [NB-1:0]      o_quot
);
    localparam int CB = $clog2(NB + 1);
    logic [NB-1:0] r_q, n_q;
    logic [DB:0]   r_rem, n_rem;
    logic [DB-1:0] r_den;
    logic [CB-1:0] r_cnt;
    logic          r_neg, r_busy;
    logic [DB:0]   w_trial;
    logic [NB-1:0] w_abs;

    assign w_abs = i_num[NB-1] ? (~i_num + 1'b1) : i_num;

    // one restoring step
    always_comb begin
        w_trial = {r_rem[DB-1:0], r_q[NB-1]};
        n_rem = w_trial;
        n_q = {r_q[NB-2:0], 1'b0};
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        o_done <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CB'(NB);
            r_q    <= w_abs;
            r_rem  <= '0;
            r_den  <= i_den;
            r_neg  <= i_num[NB-1];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CB'(1)) begin
                r_busy <= 1'b0;
                o_done <= 1'b1;
            end
        end
        if (!i_rst_n) o_done <= 1'b0;
    end

    assign o_quot = r_neg ? (~r_q + 1'b1) : r_q;
endmodule
`default_nettype wire

@@ src/stl_lpca_front.sv @@
// Front end: accepts samples and queues them for the back end.
// Depends on stl_lpca_if.
`default_nettype none
module stl_lpca_front #(
    parameter int SB = 24
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    stl_lpca_if.sink   in_ch,
    output logic       o_q_valid,
    output logic [SB:0] o_q_data,
    input  wire logic  i_q_pop
);
    // two-entry queue
    logic [SB:0] r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        w_push;

    assign in_ch.ready = (r_cnt != 2'd2);
    assign w_push = in_ch.valid && in_ch.ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= in_ch.data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule
`default_nettype wire

@@ src/stl_lpca_back.sv @@
// Back end: running sums, ring memories and the divide sequencer.
// Depends on stl_lpca_pkg, stl_lpca_if and stl_lpca_div.
`default_nettype none
module stl_lpca_back #(
    parameter int MP = 256,
    parameter int SB = 24
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_q_valid,
    input  wire logic [SB:0]                     i_q_data,
    output logic                                 o_q_pop,
    input  wire logic [stl_lpca_pkg::PeriodBits-1:0] i_period,
    input  wire logic                            i_clear,
    stl_lpca_if.source                           out_ch
);
    import stl_lpca_pkg::*;
    localparam int AB = (MP > 1) ? $clog2(MP) : 1;
    localparam int CW = $clog2(MP + 1);
    localparam int SW = SB + CW + 1;
    localparam int PB = (CW > PeriodBits) ? CW : PeriodBits;

    t_bk_state r_st, n_st;
    logic [SB-1:0] r_raw [MP];
    logic [SB-1:0] r_av1 [MP];
    logic [SB-1:0] r_rd_raw, r_rd_av1;
    logic signed [SW-1:0] r_s1, r_s2;
    logic signed [SB+2:0] r_s3;
    logic signed [SB-1:0] r_h1, r_a2;
    logic [CW-1:0] r_c0, r_c1;
    logic [1:0]    r_c2;
    logic [AB-1:0] r_pos;
    logic signed [SB-1:0] r_smp;
    logic r_last, r_ov;
    logic signed [SB-1:0] r_out;
    logic [PB-1:0] w_p;

    // effective period
    always_comb begin
        if (i_period == '0) w_p = PB'(1);
        else if (PB'(i_period) > PB'(MP)) w_p = PB'(MP);
        else w_p = PB'(i_period);
    end
    logic [CW-1:0] w_pc;
    assign w_pc = CW'(w_p);
    logic w_full0;
    assign w_full0 = r_c0 >= w_pc;

    logic div_start, div_done;
    logic [SW-1:0] div_num, div_q;
    logic [PB-1:0] div_den;
    stl_lpca_div #(.NB(SW), .DB(PB)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(div_num), .i_den(div_den), .o_done(div_done), .o_quot(div_q));

    logic out_go;
    assign out_go = out_ch.ready || !r_ov;
    assign o_q_pop = (r_st == t_BK_IDLE) && i_q_valid;

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            t_BK_IDLE: if (i_q_valid) n_st = t_BK_RD;
            t_BK_RD:   n_st = div_start ? t_BK_DIV1 : t_BK_IDLE;
            t_BK_DIV1: if (div_done) n_st = (r_c1 >= w_pc || r_c1 + 1'b1 >= w_pc)
                                          ? t_BK_DIV2 : t_BK_IDLE;
            t_BK_DIV2: if (div_done) n_st = (r_c2 == 2'd2) ? t_BK_DIV3 : t_BK_IDLE;
            t_BK_DIV3: if (div_done) n_st = t_BK_OUT;
            t_BK_OUT:  if (out_go) n_st = t_BK_IDLE;
            default:   n_st = t_BK_IDLE;
        endcase
    end

    logic signed [SW-1:0] w_s1n, w_s2n;
    assign w_s1n = (w_full0 ? r_s1 - SW'($signed(r_rd_raw)) : r_s1) + SW'(r_smp);
    assign w_s2n = (r_c1 >= w_pc ? r_s2 - SW'($signed(r_rd_av1)) : r_s2)
                   + SW'($signed(div_q[SB-1:0]));

    // divider operands
    always_comb begin
        div_start = 1'b0;
        div_num = '0;
        div_den = w_p;
        unique case (r_st)
            t_BK_RD: begin
                div_num = w_s1n;
                div_start = (r_c0 + 1'b1 >= w_pc) || w_full0;
            end
            t_BK_DIV1: begin
                div_num = w_s2n;
                div_start = div_done && (r_c1 + 1'b1 >= w_pc || r_c1 >= w_pc);
            end
            t_BK_DIV2: begin
                div_num = SW'(r_s3 + SW'($signed(div_q[SB-1:0])));
                div_den = PB'(3);
                div_start = div_done && (r_c2 == 2'd2);
            end
            default: ;
        endcase
    end

    logic w_fin;
    always_comb begin
        w_fin = 1'b0;
        unique case (r_st)
            t_BK_RD:   w_fin = !div_start;
            t_BK_DIV1: w_fin = div_done && !div_start;
            t_BK_DIV2: w_fin = div_done && !div_start;
            t_BK_OUT:  w_fin = out_go;
            default:   w_fin = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_raw <= r_raw[r_pos];
        r_rd_av1 <= r_av1[r_pos];
        if (r_st == t_BK_RD) r_raw[r_pos] <= r_smp;
        if (r_st == t_BK_DIV1 && div_done) r_av1[r_pos] <= div_q[SB-1:0];
        if (o_q_pop) begin
            r_smp  <= $signed(i_q_data[SB:1]);
            r_last <= i_q_data[0];
        end
        if (!i_rst_n) begin
            r_st <= t_BK_IDLE; r_ov <= 1'b0;
            r_s1 <= '0; r_s2 <= '0; r_s3 <= '0;
            r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_pos <= '0;
        end else begin
            r_st <= n_st;
            if (out_ch.valid && out_ch.ready) r_ov <= 1'b0;
            // stage one
            if (r_st == t_BK_RD) begin
                r_s1 <= w_s1n;
                if (!w_full0) r_c0 <= r_c0 + 1'b1;
            end
            // stage two
            if (r_st == t_BK_DIV1 && div_done) begin
                r_s2 <= w_s2n;
                if (r_c1 < w_pc) r_c1 <= r_c1 + 1'b1;
            end
            // stage three
            if (r_st == t_BK_DIV2 && div_done) begin
                r_a2 <= $signed(div_q[SB-1:0]);
                if (r_c2 != 2'd2) begin
                    r_s3 <= r_s3 + (SB+3)'($signed(div_q[SB-1:0]));
                    r_h1 <= $signed(div_q[SB-1:0]);
                    r_c2 <= r_c2 + 1'b1;
                end
            end
            if (r_st == t_BK_DIV3 && div_done) begin
                r_out <= div_q[SB-1:0];
                r_s3 <= (SB+3)'(r_h1) + (SB+3)'(r_a2);
                r_h1 <= r_a2;
            end
            if (r_st == t_BK_OUT && out_go) begin
                r_ov <= 1'b1;
                out_ch.data <= {r_out, r_last};
            end
            // end of sample
            if (w_fin) begin
                r_pos <= (CW'(r_pos) + 1'b1 >= w_pc) ? '0 : r_pos + 1'b1;
                if (r_last) begin
                    r_s1 <= '0; r_s2 <= '0; r_s3 <= '0;
                    r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_pos <= '0;
                end
            end
            if (i_clear) begin
                r_s1 <= '0; r_s2 <= '0; r_s3 <= '0;
                r_c0 <= '0; r_c1 <= '0; r_c2 <= '0; r_pos <= '0;
            end
        end
    end
    assign out_ch.valid = r_ov;
endmodule
`default_nettype wire

@@ src/stl_lowpass_cascade_average.sv @@
// STL seasonal low-pass: three cascaded moving averages (period, period, 3).
// The averages share one bit-serial divider, so the back end finishes each sample before
// taking the next; the front end queues incoming samples meanwhile.
// Reset (i_rst_n low, synchronous) clears sums, counts and ring position; period = 12.
// Ring memories hold no reset; entries are only used after being written.
`default_nettype none
module stl_lowpass_cascade_average #(
    parameter int MAX_PERIOD  = 256,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stl_lpca_if.sink   i_in,
    stl_lpca_if.source o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [stl_lpca_pkg::CfgAddrBits+1:0] paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import stl_lpca_pkg::*;
    logic [PeriodBits-1:0] r_period;
    logic w_wr, w_qv, w_pop;
    logic [SAMPLE_BITS:0] w_qd;

    assign pready = 1'b1;
    assign w_wr = psel && penable && pwrite && (paddr[CfgAddrBits+1:2] == RegPeriod);
    assign prdata = {{(32-PeriodBits){1'b0}}, r_period};

    // period register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_period <= PeriodReset;
        else if (w_wr) r_period <= pwdata[PeriodBits-1:0];
    end

    stl_lpca_front #(.SB(SAMPLE_BITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .in_ch(i_in),
        .o_q_valid(w_qv), .o_q_data(w_qd), .i_q_pop(w_pop));

    stl_lpca_back #(.MP(MAX_PERIOD), .SB(SAMPLE_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_valid(w_qv), .i_q_data(w_qd),
        .o_q_pop(w_pop), .i_period(r_period), .i_clear(w_wr), .out_ch(o_out));
endmodule
`default_nettype wire

@@ dv/stl_lowpass_cascade_average_tb.sv @@
// Testbench for the STL low-pass cascade average: drives series over the sample channel
// and the APB port, predicts results with a scoreboard class and checks each transfer.
// Depends on stl_lpca_pkg, stl_lpca_if and stl_lowpass_cascade_average.
`default_nettype none
module stl_lowpass_cascade_average_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import stl_lpca_pkg::*;

    localparam int MaxPeriod = 256;
    localparam int WatchLimit = 5000;
    localparam int SettleCycles = 600;
    localparam int ItemTarget = 1560;

    typedef struct packed {
        logic signed [23:0] value;
        logic               done;
    } smooth_t;

    // Cascade predictor and store of expected smoothed values
    class cascade_scoreboard;
        int unsigned period_reg;
        longint      raw_ring [MaxPeriod];
        longint      avg_ring [MaxPeriod];
        longint      hist [2];
        longint      sum1, sum2, sum3;
        int unsigned fill [3];
        int unsigned slot;
        smooth_t     expected_q [$];
        int          errors;
        int          seen;

        function new();
            period_reg = PeriodReset;
            errors = 0;
            seen = 0;
            clear_series();
        endfunction

        function void clear_series();
            sum1 = 0;
            sum2 = 0;
            sum3 = 0;
            fill[0] = 0;
            fill[1] = 0;
            fill[2] = 0;
            slot = 0;
        endfunction

        function void set_period(int unsigned v);
            period_reg = v & 'h1FF;
            clear_series();
        endfunction

        // Advance the three averages by one accepted sample
        function void note_sample(logic signed [23:0] s, logic last);
            int unsigned p;
            int unsigned pos;
            longint a1, a2, a3;
            smooth_t r;
            p = (period_reg == 0) ? 1 : (period_reg > MaxPeriod ? MaxPeriod : period_reg);
            pos = (slot >= p) ? 0 : slot;
            if (fill[0] >= p) sum1 -= raw_ring[pos];
            else fill[0]++;
            raw_ring[pos] = s;
            sum1 += s;
            if (fill[0] >= p) begin
                a1 = sum1 / longint'(p);
                if (fill[1] >= p) sum2 -= avg_ring[pos];
                else fill[1]++;
                avg_ring[pos] = a1;
                sum2 += a1;
                if (fill[1] >= p) begin
                    a2 = sum2 / longint'(p);
                    if (fill[2] >= 2) begin
                        a3 = (sum3 + a2) / 3;
                        r.value = a3[23:0];
                        r.done = last;
                        expected_q.push_back(r);
                        sum3 = hist[1] + a2;
                        hist[0] = hist[1];
                        hist[1] = a2;
                    end else begin
                        hist[fill[2] & 1] = a2;
                        sum3 += a2;
                        fill[2]++;
                    end
                end
            end
            pos++;
            if (pos >= p) pos = 0;
            slot = pos;
            if (last) clear_series();
        endfunction

        function void check_result(smooth_t got);
            smooth_t exp_r;
            seen++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result value=%0d done=%0b", $time,
                         got.value, got.done);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.value !== exp_r.value)
                $display("%0t: smoothed mismatch expected=%0d actual=%0d", $time,
                         exp_r.value, got.value);
            if (got.done !== exp_r.done)
                $display("%0t: series_done mismatch expected=%0b actual=%0b", $time,
                         exp_r.done, got.done);
            if (got.value !== exp_r.value || got.done !== exp_r.done) errors++;
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [CfgAddrBits+1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    stl_lpca_if #(.W(25)) in_if ();
    stl_lpca_if #(.W(25)) out_if ();

    stl_lowpass_cascade_average dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    cascade_scoreboard sb;
    int idle_cycles;
    int stall_left;
    bit pressure_done;
    int items_sent;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        idle_cycles = 0;
        stall_left = 0;
        pressure_done = 1'b0;
        items_sent = 0;
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit) begin
            $display("stl_lowpass_cascade_average_tb: done, errors");
            $finish;
        end
    end

    // Result side: check each transfer, then stall at random
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) sb.check_result(smooth_t'(out_if.data));
            if (!pressure_done && sb.seen >= 20) begin
                pressure_done = 1'b1;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                out_if.ready <= 1'b0;
                stall_left--;
            end else begin
                int r;
                r = $urandom_range(0, 99);
                out_if.ready <= 1'b1;
                if (r < 15) stall_left = $urandom_range(1, 3);
                else if (r < 17) stall_left = $urandom_range(20, 80);
            end
        end
    end

    task automatic gap_cycles();
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 55) n = 0;
        else if (r < 95) n = $urandom_range(1, 4);
        else n = $urandom_range(20, 100);
        if (n > 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Offer one sample and hold it until the transfer
    task automatic send_sample(logic signed [23:0] s, logic last);
        in_if.valid <= 1'b1;
        in_if.data <= {s, last};
        do @(posedge i_clk); while (!in_if.ready);
        sb.note_sample(s, last);
        items_sent++;
        gap_cycles();
    endtask

    task automatic settle();
        in_if.valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_period(int unsigned v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {RegPeriod, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.set_period(v);
    endtask

    function automatic logic signed [23:0] rand_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 24'sh7FFFFF;
        if (r == 1) return 24'sh800000;
        return 24'($urandom());
    endfunction

    // One series of n samples; the last carries the end flag when closed
    task automatic send_series(int n, bit closed);
        for (int k = 0; k < n; k++)
            send_sample(rand_sample(), closed && (k == n - 1));
    endtask

    function automatic int eff_period(int unsigned v);
        v = v & 'h1FF;
        return (v == 0) ? 1 : (v > MaxPeriod ? MaxPeriod : v);
    endfunction

    initial begin
        int p;
        int unsigned settings [6] = '{1, 0, 3, 511, 2, 5};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset period: extremes held flat, alternating, and a short series
        for (int k = 0; k < 26; k++) send_sample(24'sh7FFFFF, 1'b0);
        for (int k = 0; k < 30; k++) send_sample(24'sh800000, k == 29);
        for (int k = 0; k < 5; k++) send_sample(24'sh000001, k == 4);
        for (int k = 0; k < 28; k++)
            send_sample((k % 2) ? 24'sh800000 : 24'sh7FFFFF, k == 27);
        // Leave a series open; the period write drops it
        send_series(20, 1'b0);
        settle();

        // Largest window, one full series
        write_period(256);
        send_series(520, 1'b1);
        settle();

        // Random part over several settings
        while (items_sent < ItemTarget) begin
            foreach (settings[i]) begin
                if (items_sent < ItemTarget) begin
                    write_period(settings[i]);
                    p = eff_period(settings[i]);
                    repeat ((settings[i] == 511) ? 1 : 6) begin
                        if ($urandom_range(0, 9) == 0)
                            send_series($urandom_range(1, 2 * p), 1'b1);
                        else if (settings[i] == 511)
                            send_series($urandom_range(1, 40), 1'b1);
                        else send_series(2 * p + 1 + $urandom_range(0, 30), 1'b1);
                    end
                    send_series($urandom_range(0, 8), 1'b0);
                    settle();
                end
            end
        end
        write_period(PeriodReset);
        send_series(40, 1'b1);
        settle();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("stl_lowpass_cascade_average_tb: done, clean");
        else
            $display("stl_lowpass_cascade_average_tb: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
